### src/rbsi_pkg.sv
// Package for the ray/box slab intersection block.
// Holds payload structs, divider stage types and shared constants; no dependencies.
`default_nettype none
package rbsi_pkg;

    localparam int WORD_W = 32;
    // Numerator is (corner - origin) << 16, exact in 49 bits signed.
    localparam int NUM_W  = 49;
    // Magnitude of the numerator fits in 48 bits.
    localparam int MAG_W  = 48;
    // One quotient bit per divider cell.
    localparam int QBITS  = 48;

    localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_req_t;

    typedef struct packed {
        logic        is_hit;
        logic [30:0] hit_distance;
        logic        from_inside;
    } ray_res_t;

    // One restoring division in flight: remainder, pending numerator bits,
    // divisor magnitude, sign information and a zero-divisor flag.
    typedef struct packed {
        logic [MAG_W:0]   rem;
        logic [MAG_W-1:0] num;
        logic [31:0]      den;
        logic             neg;
        logic             num_neg;
        logic             dzero;
    } div_lane_t;

endpackage
`default_nettype wire

### src/rbsi_div_cell.sv
// One cell of the pipelined restoring divider chain: one quotient bit per cell
// for all six slab divisions. Depends on rbsi_pkg.
`default_nettype none
module rbsi_div_cell
    import rbsi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vld_in,
    input  div_lane_t [5:0]           lane_in,
    output logic                      vld_out,
    output div_lane_t [5:0]           lane_out
);

    div_lane_t [5:0] lane_next;
    logic            vld_reg;
    div_lane_t [5:0] lane_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            logic [MAG_W:0] trial;
            logic [MAG_W:0] diff;
            trial = {lane_in[i].rem[MAG_W-1:0], lane_in[i].num[MAG_W-1]};
            diff  = trial - {{(MAG_W-31){1'b0}}, lane_in[i].den};
            lane_next[i] = lane_in[i];
            lane_next[i].num = {lane_in[i].num[MAG_W-2:0], ~diff[MAG_W]};
            lane_next[i].rem = diff[MAG_W] ? trial : diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign vld_out  = vld_reg;
    assign lane_out = lane_reg;

endmodule
`default_nettype wire

### src/ray_box_slab_intersect.sv
// Top level of the ray/box slab intersection block.
// Depends on rbsi_pkg and rbsi_div_cell.
//
// Each request carries a ray (origin, direction) in signed Q16.16; the box
// corners come from six configuration registers. The block returns one
// result per request: a hit flag, the hit distance and an inside flag.
// The six slab divisions run through a chain of 48 divider cells, one
// quotient bit each, so a new ray enters every cycle unless the output
// stalls. The path holds 51 register stages (one input stage, 48 divider
// cells, one min/max stage and one output register); the input stage
// loads at the accepting edge. The chain advances as a whole whenever the
// output register is free or being taken, so back-to-back streaming holds
// one request per cycle, and an output stall while the output register
// holds a result holds every stage.
`default_nettype none
module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int EPSILON_Q16 = 66
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  ray_req_t         in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output ray_res_t         out_data
);

    localparam logic signed [31:0] EPS = 32'(EPSILON_Q16);

    logic signed [31:0] box_lo_reg [3];
    logic signed [31:0] box_hi_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_lo_reg[i] <= '0;
                box_hi_reg[i] <= 32'sd65536;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_X: box_lo_reg[0] <= cfg_data;
                REG_MIN_Y: box_lo_reg[1] <= cfg_data;
                REG_MIN_Z: box_lo_reg[2] <= cfg_data;
                REG_MAX_X: box_hi_reg[0] <= cfg_data;
                REG_MAX_Y: box_hi_reg[1] <= cfg_data;
                REG_MAX_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipe moves when the output register can take a new value.
    logic out_valid_reg;
    logic adv;
    assign adv      = ~out_valid_reg | ~out_stall;
    assign in_stall = ~adv;

    // Entry stage: form the six numerators and divisor magnitudes.
    // The corner-origin difference never exceeds 2^32 - 1 in magnitude.
    div_lane_t [5:0] ent_next;
    div_lane_t [5:0] ent_reg;
    logic            ent_vld_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            logic signed [32:0] diff;
            logic signed [31:0] org;
            logic signed [31:0] dir;
            logic signed [31:0] corner;
            logic [31:0]        dmag;
            logic [32:0]        dabs;
            case (i % 3)
                0: begin org = in_data.origin_x; dir = in_data.dir_x; end
                1: begin org = in_data.origin_y; dir = in_data.dir_y; end
                default: begin org = in_data.origin_z; dir = in_data.dir_z; end
            endcase
            corner = (i < 3) ? box_lo_reg[i % 3] : box_hi_reg[i % 3];
            diff   = 33'(corner) - 33'(org);
            dmag   = diff[32] ? 32'(-diff) : diff[31:0];
            dabs   = dir[31] ? 33'(-33'(dir)) : 33'(dir);
            ent_next[i].rem     = '0;
            ent_next[i].num     = {dmag, 16'h0};
            ent_next[i].den     = dabs[31:0];
            ent_next[i].neg     = diff[32] ^ dir[31];
            ent_next[i].num_neg = diff[32];
            ent_next[i].dzero   = (dir == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_vld_reg <= 1'b0;
        else if (adv)
            ent_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ent_reg <= ent_next;
    end

    // Divider chain.
    logic            vld_chain  [QBITS+1];
    div_lane_t [5:0] lane_chain [QBITS+1];

    assign vld_chain[0]  = ent_vld_reg;
    assign lane_chain[0] = ent_reg;

    for (genvar g = 0; g < QBITS; g++)
    begin : g_cell
        rbsi_div_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (adv),
            .vld_in      (vld_chain[g]),
            .lane_in     (lane_chain[g]),
            .vld_out     (vld_chain[g+1]),
            .lane_out    (lane_chain[g+1])
        );
    end

    // Saturate each quotient, then order the slab pair per axis.
    logic signed [31:0] q [6];
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            div_lane_t l;
            l = lane_chain[QBITS][i];
            if (l.dzero)
                q[i] = l.num_neg ? SAT_NEG : SAT_POS;
            else if (l.neg)
                q[i] = (l.num > MAG_W'(64'h8000_0000)) ? SAT_NEG
                       : 32'(-l.num[31:0]);
            else
                q[i] = (l.num > MAG_W'(64'h7FFF_FFFF)) ? SAT_POS : l.num[31:0];
        end
    end

    logic signed [31:0] t0_next;
    logic signed [31:0] t1_next;
    always_comb
    begin
        t0_next = SAT_NEG;
        t1_next = SAT_POS;
        for (int a = 0; a < 3; a++)
        begin
            logic signed [31:0] lo;
            logic signed [31:0] hi;
            lo = (q[a] < q[a+3]) ? q[a] : q[a+3];
            hi = (q[a] < q[a+3]) ? q[a+3] : q[a];
            if (lo > t0_next)
                t0_next = lo;
            if (hi < t1_next)
                t1_next = hi;
        end
    end

    logic signed [31:0] t0_reg;
    logic signed [31:0] t1_reg;
    logic               tv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg <= 1'b0;
        else if (adv)
            tv_reg <= vld_chain[QBITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
        end
    end

    // Final decision against epsilon.
    ray_res_t res_next;
    ray_res_t res_reg;
    always_comb
    begin
        res_next = '0;
        if (t0_reg < EPS && t1_reg > EPS)
        begin
            res_next.is_hit       = 1'b1;
            res_next.hit_distance = t1_reg[30:0];
            res_next.from_inside  = 1'b1;
        end
        else if (t0_reg >= EPS && t0_reg < t1_reg)
        begin
            res_next.is_hit       = 1'b1;
            res_next.hit_distance = t0_reg[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= tv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

endmodule
`default_nettype wire
